// ===== design/gf2r_pkg.sv =====
// gf2r_pkg: shared types and fixed widths for the incremental gf(2) rank block
// no dependencies; used by every module under design/
`default_nettype none

package gf2r_pkg;

  localparam int unsigned COL_W   = 64;
  localparam int unsigned PIVOT_W = 6;
  localparam int unsigned RANK_W  = 7;

  // input beat
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic             first_of_set;
  } in_t;

  // result beat
  typedef struct packed {
    logic               independent;
    logic [PIVOT_W-1:0] pivot_bit;
    logic [RANK_W-1:0]  running_rank;
    logic [RANK_W-1:0]  deficiency;
  } out_t;

  // control that travels down the cell chain beside the column
  typedef struct packed {
    logic               valid;
    logic               clr;
    logic               indep;
    logic [PIVOT_W-1:0] pivot;
  } ctl_t;

endpackage

`default_nettype wire

// ===== design/gf2_incremental_rank.sv =====
// gf2_incremental_rank: top level, a chain of COL_BITS reduction cells and a rank tail
// depends on gf2r_pkg, gf2r_cell, gf2r_rank
//
//   port group  dir  beat type          notes
//   in_*        in   gf2r_pkg::in_t     one column per beat, first_of_set restarts the basis
//   out_*       out  gf2r_pkg::out_t    one result per column, same order
//
// one column enters per cycle while in_ready is high; a result is offered from the result
// register after passing one register per cell (highest row first), the first cell
// loading at the accepting edge
// reset clears every cell's used flag and the rank; stored rows need no clearing
// a stalled result freezes the whole chain, so in_ready follows the result register
`default_nettype none

module gf2_incremental_rank #(
  parameter int unsigned COL_BITS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire gf2r_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output gf2r_pkg::out_t      out_data
);

  // chain links: index 0 is the entry, index COL_BITS is the tail
  gf2r_pkg::ctl_t      ctl_s [0:COL_BITS];
  logic [COL_BITS-1:0] x_s   [0:COL_BITS];
  logic                advance;

  // entering beat: bits at or above COL_BITS are dropped here
  assign ctl_s[0].valid = in_valid;
  assign ctl_s[0].clr   = in_data.first_of_set;
  assign ctl_s[0].indep = 1'b0;
  assign ctl_s[0].pivot = '0;
  assign x_s[0]         = in_data.column[COL_BITS-1:0];

  // cell i handles row COL_BITS-1-i, so reduction runs from the top bit down
  for (genvar i = 0; i < COL_BITS; i++) begin : g_cell
    gf2r_cell #(
      .COL_BITS (COL_BITS),
      .POS      (COL_BITS - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .ctl_in  (ctl_s[i]),
      .x_in    (x_s[i]),
      .ctl_out (ctl_s[i+1]),
      .x_out   (x_s[i+1])
    );
  end

  // tail: rank bookkeeping and the result register
  gf2r_rank #(
    .COL_BITS (COL_BITS)
  ) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_s[COL_BITS]),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = advance;

  // chain moves as one: a taken input beat means nothing downstream is stuck
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("input taken while result stalled");

  // residue of a column that left the chain is always zero
  a_residue: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s[COL_BITS].valid |-> x_s[COL_BITS] == '0)
    else $error("column left chain unreduced");

endmodule

`default_nettype wire

// ===== design/gf2r_cell.sv =====
// gf2r_cell: one link of the reduction chain, owns the basis row whose leading bit is POS
// depends on gf2r_pkg
`default_nettype none

module gf2r_cell #(
  parameter int unsigned COL_BITS = 64,
  parameter int unsigned POS      = 63
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire gf2r_pkg::ctl_t      ctl_in,
  input  wire logic [COL_BITS-1:0] x_in,
  output gf2r_pkg::ctl_t           ctl_out,
  output logic [COL_BITS-1:0]      x_out
);

  gf2r_pkg::ctl_t      ctl_r, ctl_nxt;
  logic [COL_BITS-1:0] x_r, x_nxt;
  logic [COL_BITS-1:0] row_r, row_nxt;
  logic                used_r, used_nxt;
  logic                used_eff;

  always_comb begin
    used_eff = ctl_in.clr ? 1'b0 : used_r;
    ctl_nxt  = ctl_in;
    x_nxt    = x_in;
    used_nxt = used_r;
    row_nxt  = row_r;
    if (ctl_in.valid) begin
      used_nxt = used_eff;
      if (x_in[POS]) begin
        if (used_eff) begin
          x_nxt = x_in ^ row_r;
        end else begin
          // new leading bit: keep the reduced column here
          row_nxt       = x_in;
          used_nxt      = 1'b1;
          x_nxt         = '0;
          ctl_nxt.indep = 1'b1;
          ctl_nxt.pivot = gf2r_pkg::PIVOT_W'(POS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      used_r <= 1'b0;
    end else if (advance) begin
      ctl_r  <= ctl_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_r   <= x_nxt;
      row_r <= row_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;

  // a stored row always leads with this cell's bit
  a_row_lead: assert property (@(posedge clk) disable iff (!rst_n)
    used_r |-> row_r[POS])
    else $error("stored row lacks its leading bit");

  // once past this cell a column has no bit at or above POS
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.valid |-> (x_r >> POS) == '0)
    else $error("column not reduced below cell position");

endmodule

`default_nettype wire

// ===== design/gf2r_rank.sv =====
// gf2r_rank: tail of the chain, keeps the running rank and holds the result beat
// depends on gf2r_pkg
`default_nettype none

module gf2r_rank #(
  parameter int unsigned COL_BITS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire gf2r_pkg::ctl_t ctl_in,
  output logic                advance,
  output logic                out_valid,
  input  wire logic           out_ready,
  output gf2r_pkg::out_t      out_data
);

  localparam logic [gf2r_pkg::RANK_W-1:0] FULL = gf2r_pkg::RANK_W'(COL_BITS);

  logic [gf2r_pkg::RANK_W-1:0] rank_r, rank_nxt;
  logic                        vld_r;
  gf2r_pkg::out_t              res_r, res_nxt;

  assign advance = !vld_r || out_ready;

  always_comb begin
    rank_nxt = ctl_in.clr ? '0 : rank_r;
    rank_nxt = rank_nxt + gf2r_pkg::RANK_W'(ctl_in.indep);
    res_nxt.independent  = ctl_in.indep;
    res_nxt.pivot_bit    = ctl_in.pivot;
    res_nxt.running_rank = rank_nxt;
    res_nxt.deficiency   = FULL - rank_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
      vld_r  <= 1'b0;
    end else if (advance) begin
      vld_r <= ctl_in.valid;
      if (ctl_in.valid) begin
        rank_r <= rank_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctl_in.valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = res_r;

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rank_r <= FULL)
    else $error("rank above column width");

  a_defic: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (res_r.running_rank + res_r.deficiency) == FULL)
    else $error("rank and deficiency disagree");

  a_dep_pivot: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !res_r.independent) |-> res_r.pivot_bit == '0)
    else $error("dependent column reports a pivot");

endmodule

`default_nettype wire

// ===== dv/tb_gf2_incremental_rank.sv =====
// tb_gf2_incremental_rank: self-checking bench for the incremental gf(2) rank block
// depends on gf2r_pkg and gf2_incremental_rank; keeps its own copy of the pivot basis
// and checks every result beat field by field, in order
`default_nettype none

module tb_gf2_incremental_rank;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COL_BITS    = 64;
  localparam int unsigned NUM_COLUMNS = 1050;
  localparam int unsigned CYCLE_LIMIT = 600000;
  // final wait before the verdict, covering the chain and the result register
  localparam int unsigned DRAIN_CYCLES = COL_BITS + 8;

  // one pending column beat plus the idle time the sender takes after it
  typedef struct packed {
    gf2r_pkg::in_t beat;
    logic [7:0]    gap;
    logic          drain;   // hold this beat back until every result is home
  } feed_item_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  gf2r_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  gf2r_pkg::out_t out_data;

  feed_item_t     column_feed[$];
  gf2r_pkg::out_t pending_results[$];

  // bench copy of the echelon basis, one row per leading bit
  logic [63:0] basis_rows [64];
  logic [63:0] basis_used = '0;
  logic [6:0]  basis_rank = '0;

  int unsigned mismatch_count = 0;
  int unsigned received_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_left = 0;
  int unsigned stall_left = 0;
  bit          long_hold_done = 1'b0;

  gf2_incremental_rank #(.COL_BITS(COL_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // queue helpers
  function automatic void append_feed(feed_item_t item);
    column_feed.insert(column_feed.size(), item);
  endfunction

  function automatic void append_expect(gf2r_pkg::out_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  // reduce one column against the basis, highest row first; xor with the row that
  // owns bit p only touches bits at or below p, so one downward sweep is enough
  function automatic gf2r_pkg::out_t reduce_against_basis(gf2r_pkg::in_t beat);
    gf2r_pkg::out_t res;
    logic [63:0]    x;
    logic           placed;
    x      = beat.column;
    placed = 1'b0;
    res    = '0;
    if (beat.first_of_set) begin
      basis_used = '0;
      basis_rank = '0;
    end
    // rows at or above COL_BITS never enter the sweep, which masks them off
    for (int p = COL_BITS - 1; p >= 0; p--) begin
      if (!placed && x[p]) begin
        if (!basis_used[p]) begin
          basis_rows[p] = x;
          basis_used[p] = 1'b1;
          if (basis_rank < 7'd64) basis_rank = basis_rank + 7'd1;
          res.independent = 1'b1;
          res.pivot_bit   = gf2r_pkg::PIVOT_W'(p);
          placed          = 1'b1;
        end else begin
          x = x ^ basis_rows[p];
        end
      end
    end
    res.running_rank = basis_rank;
    res.deficiency   = gf2r_pkg::RANK_W'(COL_BITS) - basis_rank;
    return res;
  endfunction

  // driver: presents the head of the feed, predicts on every accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else begin
      if (in_valid && in_ready)
        append_expect(reduce_against_basis(in_data));
      // slot is free when nothing is offered or the offer just went through
      if (!in_valid || in_ready) begin
        if (idle_left != 0) begin
          in_valid  <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (column_feed.size() != 0 &&
                     !(column_feed[0].drain && pending_results.size() != 0)) begin
          in_data   <= column_feed[0].beat;
          in_valid  <= 1'b1;
          idle_left <= column_feed[0].gap;
          void'(column_feed.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest prediction, drives out_ready
  always @(posedge clk) begin
    gf2r_pkg::out_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        received_count++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat expected none actual %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          if (out_data.independent !== want.independent) begin
            mismatch_count++;
            $display("%0t: independent expected %h actual %h", $time,
                     want.independent, out_data.independent);
          end
          if (out_data.pivot_bit !== want.pivot_bit) begin
            mismatch_count++;
            $display("%0t: pivot_bit expected %0d actual %0d", $time,
                     want.pivot_bit, out_data.pivot_bit);
          end
          if (out_data.running_rank !== want.running_rank) begin
            mismatch_count++;
            $display("%0t: running_rank expected %0d actual %0d", $time,
                     want.running_rank, out_data.running_rank);
          end
          if (out_data.deficiency !== want.deficiency) begin
            mismatch_count++;
            $display("%0t: deficiency expected %0d actual %0d", $time,
                     want.deficiency, out_data.deficiency);
          end
        end
      end
      // one long hold-off while the sender keeps streaming, so the chain backs up
      if (!long_hold_done && received_count >= 300) begin
        long_hold_done = 1'b1;
        out_ready  <= 1'b0;
        stall_left <= 300;
      end else if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (received_count >= 650 && received_count < 800) begin
        // stretch with the receiver always ready
        out_ready <= 1'b1;
      end else begin
        stall_left <= pick_gap();
        out_ready  <= (stall_left == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gf2_incremental_rank regression: fail");
      $finish;
    end
  end

  // stimulus build, reset, end of test
  initial begin
    logic [63:0] set_cols[$];
    logic [63:0] col;
    logic [63:0] width_mask;
    feed_item_t  item;
    int unsigned set_len;
    int unsigned width;
    int unsigned mode;
    int unsigned idx;
    bit          noisy;

    // directed: first column with no restart lands in the empty basis after reset
    idx = 0;
    item = '0;
    for (int d = 0; d < 16; d++) begin
      item = '0;
      unique case (d)
        0:  item.beat.column = 64'h8000_0000_0000_0000;  // top row, no restart
        1:  item.beat.column = 64'h0;                    // zero column
        2:  item.beat.column = '1;                       // all ones, reduces to pivot 62
        3:  item.beat.column = '1;                       // repeat, dependent
        4:  item.beat.column = 64'h1;                    // bottom row
        5:  item.beat.column = 64'h8000_0000_0000_0001;  // sum of two stored rows
        6:  item.beat.column = 64'hAAAA_AAAA_AAAA_AAAA;
        7:  item.beat.column = 64'h5555_5555_5555_5555;
        8:  item.beat.column = 64'h7FFF_FFFF_FFFF_FFFE;  // now in the span
        9: begin                                         // restart with a zero column
          item.beat.column       = 64'h0;
          item.beat.first_of_set = 1'b1;
        end
        10: item.beat.column = 64'h4000_0000_0000_0000;
        11: begin                                        // restart straight into a pivot
          item.beat.column       = 64'hFFFF_FFFF_0000_0000;
          item.beat.first_of_set = 1'b1;
        end
        12: item.beat.column = 64'h0000_0000_FFFF_FFFF;
        13: item.beat.column = 64'hFFFF_FFFF_FFFF_FFFF;  // dependent on the two halves
        14: begin
          item.beat.column       = 64'h1;
          item.beat.first_of_set = 1'b1;
        end
        default: begin
          item.beat.column = 64'h1;
          item.drain       = 1'b1;                      // sender waits for the pipe to empty
        end
      endcase
      item.gap = (d < 8) ? 8'd0 : 8'(pick_gap());
      append_feed(item);
      idx++;
    end

    // random: mostly well-formed sets with mixed independent and dependent columns
    while (idx < NUM_COLUMNS) begin
      set_cols.delete();
      set_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 24);
      width   = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 16) : 64;
      width_mask = (width == 64) ? '1 : ((64'h1 << width) - 64'h1);
      noisy   = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < set_len && idx < NUM_COLUMNS; k++) begin
        mode = $urandom_range(0, 19);
        if (mode < 8) begin
          col = {$urandom(), $urandom()};
        end else if (mode < 11) begin
          col = 64'h1 << $urandom_range(0, 63);
        end else if (mode < 13) begin
          col = (64'h1 << $urandom_range(0, 63)) | (64'h1 << $urandom_range(0, 63)) |
                (64'h1 << $urandom_range(0, 63));
        end else if (mode < 18 && set_cols.size() != 0) begin
          // xor of earlier columns of this set, dependent unless a restart fell inside the set
          col = '0;
          foreach (set_cols[j])
            if ($urandom_range(0, 1) == 1) col = col ^ set_cols[j];
        end else if (mode == 18) begin
          col = '0;
        end else begin
          col = ~(64'h0) >> $urandom_range(0, 63);
        end
        col = col & width_mask;
        set_cols.insert(set_cols.size(), col);
        item = '0;
        item.beat.column = col;
        item.beat.first_of_set = (k == 0) || (noisy && $urandom_range(0, 7) == 0);
        // sender streams with no gaps across the receiver's long hold-off
        item.gap   = (idx >= 280 && idx < 480) ? 8'd0 : 8'(pick_gap());
        item.drain = (idx == 600);
        append_feed(item);
        idx++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (column_feed.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("gf2_incremental_rank regression: pass");
    end else begin
      $display("gf2_incremental_rank regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== gf2_incremental_rank.f =====
design/gf2r_pkg.sv
design/gf2r_cell.sv
design/gf2r_rank.sv
design/gf2_incremental_rank.sv
dv/tb_gf2_incremental_rank.sv
